// ===== rtl/scanline_seed_fill_engine_top_macros.svh =====
// Assertion helpers used by the fill engine top module
`ifndef SCANLINE_SEED_FILL_ENGINE_TOP_MACROS_SVH
`define SCANLINE_SEED_FILL_ENGINE_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define SSF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property including during reset
`define SSF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ssfe_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfe_pkg
// Types, constants and codes shared by the scanline seed fill engine.
// ----------------------------------------------------------------------------
package ssfe_pkg;

    localparam int FRAME_WIDTH_DEF  = 256;
    localparam int FRAME_HEIGHT_DEF = 256;
    localparam int STACK_DEPTH_DEF  = 1024;

    localparam int COLOUR_W = 24;
    localparam int COUNT_W  = 17;
    localparam int COORD_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FILL  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef enum logic {
        REG_FILL_COLOUR     = 1'b0,
        REG_BOUNDARY_COLOUR = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  y_coord;
        logic [COLOUR_W-1:0] pixel_colour;
    } t_in_item;

    typedef struct packed {
        logic [COLOUR_W-1:0] read_colour;
        logic [COUNT_W-1:0]  painted_count;
        logic [1:0]          status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_POP_WAIT,
        S_LEFT_RD,
        S_LEFT_CHK,
        S_RIGHT_RD,
        S_RIGHT_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_NEXT,
        S_READ_WAIT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/scanline_seed_fill_engine_top.sv =====
// ----------------------------------------------------------------------------
// scanline_seed_fill_engine_top
// Frame store with pixel write/read and a scanline seed fill sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid/o_in_ready, i_in_data) carries one command beat:
//  write pixel, read pixel, seed fill or no-op. Each beat yields one result
//  beat on (o_out_valid/i_out_ready, o_out_data).
//  Writes and no-ops end at accept; a read passes through accept, frame store
//  read and result. A fill walks the frame store one pixel access at a time
//  over its single port: a read and a check per pixel painted beyond the seed
//  and per pixel scanned; pop, seed paint, both edge checks and row switches
//  per popped seed; a final pop and result. Input is held off until a read
//  or fill is done. Configuration registers (fill and boundary colour) are
//  written through i_cfg_we/i_cfg_index/i_cfg_data only while the block is
//  idle, a rule the block leaves to the user. Coordinates outside the frame
//  give status 2. The result is registered; an idle block takes the next
//  command when presented, stalling only while the result register is full.
//  Reset clears control state and sets both colours to 0xFFFFFF; frame store
//  and seed stack contents are undefined until written. No clearing pass.
// ----------------------------------------------------------------------------
`include "scanline_seed_fill_engine_top_macros.svh"

module scanline_seed_fill_engine_top #(
    parameter int FRAME_WIDTH  = ssfe_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = ssfe_pkg::FRAME_HEIGHT_DEF,
    parameter int STACK_DEPTH  = ssfe_pkg::STACK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ssfe_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ssfe_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [23:0]          i_cfg_data
);
    localparam int XW  = $clog2(FRAME_WIDTH);
    localparam int YW  = $clog2(FRAME_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LW  = SAW + 1;
    localparam int CW  = ssfe_pkg::COLOUR_W;
    localparam logic [XW-1:0] X_LAST = XW'(FRAME_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(FRAME_HEIGHT - 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

    // memories; the frame is addressed as {y, x}
    logic [CW-1:0] r_frame [2**AW];
    logic [AW-1:0] r_stack [STACK_DEPTH];
    logic [CW-1:0] r_frame_q;
    logic [AW-1:0] r_stack_q;

    logic          fr_we, fr_re;
    logic [AW-1:0] fr_addr;
    logic [CW-1:0] fr_wdata;
    logic          st_we, st_re;
    logic [SAW-1:0] st_addr;
    logic [AW-1:0] st_wdata;

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            r_frame[fr_addr] <= fr_wdata;
        end
        if (fr_re) begin
            r_frame_q <= r_frame[fr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stack[st_addr] <= st_wdata;
        end
        if (st_re) begin
            r_stack_q <= r_stack[st_addr];
        end
    end

    // registers
    ssfe_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_fill_col, r_bnd_col;
    logic [LW-1:0] r_level, n_level;
    logic [XW-1:0] r_cx, n_cx, r_xl, n_xl, r_xr, n_xr, r_x, n_x;
    logic [YW-1:0] r_cy, n_cy, r_sy, n_sy;
    logic          r_down, n_down;    // scanning row below (1) or above (0)
    logic          r_inrun, n_inrun;
    logic [ssfe_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    ssfe_pkg::t_out_item r_out, n_out;
    logic          r_is_read, n_is_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssfe_pkg::S_IDLE;
            r_fill_col  <= '1;
            r_bnd_col   <= '1;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (ssfe_pkg::t_reg_index'(i_cfg_index))
                    ssfe_pkg::REG_FILL_COLOUR:     r_fill_col <= i_cfg_data;
                    ssfe_pkg::REG_BOUNDARY_COLOUR: r_bnd_col  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx <= n_cx; r_cy <= n_cy; r_xl <= n_xl; r_xr <= n_xr;
        r_x <= n_x; r_sy <= n_sy; r_down <= n_down; r_inrun <= n_inrun;
        r_cnt <= n_cnt; r_ovf <= n_ovf; r_out <= n_out; r_is_read <= n_is_read;
    end

    logic in_fire, out_free, in_frame, push_ok;
    logic is_bnd, is_closed;
    logic [ssfe_pkg::COUNT_W-1:0] cnt_inc;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_fire  = i_in_valid && o_in_ready;
    assign in_frame = ({8'd0, i_in_data.x_coord} < 16'(FRAME_WIDTH))
                   && ({8'd0, i_in_data.y_coord} < 16'(FRAME_HEIGHT));
    assign is_bnd    = (r_frame_q == r_bnd_col);
    assign is_closed = is_bnd || (r_frame_q == r_fill_col);
    assign cnt_inc   = (r_cnt == ssfe_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign push_ok   = (r_level < LEVEL_FULL);

    assign o_in_ready  = (r_state == ssfe_pkg::S_IDLE) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssfe_pkg::S_IDLE: begin
                if (in_fire && in_frame) begin
                    if (ssfe_pkg::t_opcode'(i_in_data.opcode) == ssfe_pkg::OP_READ) begin
                        n_state = ssfe_pkg::S_READ_WAIT;
                    end else if (ssfe_pkg::t_opcode'(i_in_data.opcode)
                                 == ssfe_pkg::OP_FILL) begin
                        n_state = ssfe_pkg::S_POP;
                    end
                end
            end
            ssfe_pkg::S_READ_WAIT: n_state = ssfe_pkg::S_DONE;
            ssfe_pkg::S_POP: begin
                n_state = (r_level == '0) ? ssfe_pkg::S_DONE : ssfe_pkg::S_POP_WAIT;
            end
            ssfe_pkg::S_POP_WAIT: n_state = ssfe_pkg::S_LEFT_RD;
            ssfe_pkg::S_LEFT_RD: begin
                n_state = (r_xl == '0) ? ssfe_pkg::S_RIGHT_RD : ssfe_pkg::S_LEFT_CHK;
            end
            ssfe_pkg::S_LEFT_CHK: begin
                n_state = is_bnd ? ssfe_pkg::S_RIGHT_RD : ssfe_pkg::S_LEFT_RD;
            end
            ssfe_pkg::S_RIGHT_RD: begin
                if (r_xr == X_LAST) begin
                    n_state = ssfe_pkg::S_SCAN_NEXT;
                end else begin
                    n_state = ssfe_pkg::S_RIGHT_CHK;
                end
            end
            ssfe_pkg::S_RIGHT_CHK: begin
                n_state = is_bnd ? ssfe_pkg::S_SCAN_NEXT : ssfe_pkg::S_RIGHT_RD;
            end
            ssfe_pkg::S_SCAN_NEXT: begin
                if ((!r_down && r_cy != Y_LAST) || r_cy != '0) begin
                    n_state = ssfe_pkg::S_SCAN_RD;
                end else begin
                    n_state = ssfe_pkg::S_POP;
                end
            end
            ssfe_pkg::S_SCAN_RD: n_state = ssfe_pkg::S_SCAN_CHK;
            ssfe_pkg::S_SCAN_CHK: begin
                if (r_x == r_xr) begin
                    n_state = r_down ? ssfe_pkg::S_SCAN_NEXT : ssfe_pkg::S_POP;
                end else begin
                    n_state = ssfe_pkg::S_SCAN_RD;
                end
            end
            ssfe_pkg::S_DONE: n_state = ssfe_pkg::S_IDLE;
            default: n_state = ssfe_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_level = r_level; n_cx = r_cx; n_cy = r_cy; n_xl = r_xl; n_xr = r_xr;
        n_x = r_x; n_sy = r_sy; n_down = r_down; n_inrun = r_inrun;
        n_cnt = r_cnt; n_ovf = r_ovf; n_out = r_out; n_is_read = r_is_read;
        n_out_valid = r_out_valid && !i_out_ready;
        fr_we = 1'b0; fr_re = 1'b0; fr_addr = {r_cy, r_cx}; fr_wdata = r_fill_col;
        st_we = 1'b0; st_re = 1'b0; st_addr = r_level[SAW-1:0];
        st_wdata = {r_sy, r_x};
        unique case (r_state)
            ssfe_pkg::S_IDLE: begin
                fr_addr  = {YW'(i_in_data.y_coord), XW'(i_in_data.x_coord)};
                fr_wdata = i_in_data.pixel_colour;
                st_addr  = '0;
                st_wdata = {YW'(i_in_data.y_coord), XW'(i_in_data.x_coord)};
                if (in_fire) begin
                    n_out = '0;
                    n_is_read = 1'b0;
                    if (!in_frame && i_in_data.opcode != ssfe_pkg::OP_NOP) begin
                        n_out.status = ssfe_pkg::ST_OUTSIDE;
                        n_out_valid = 1'b1;
                    end else begin
                        unique case (ssfe_pkg::t_opcode'(i_in_data.opcode))
                            ssfe_pkg::OP_WRITE: begin
                                fr_we = 1'b1;
                                n_out_valid = 1'b1;
                            end
                            ssfe_pkg::OP_READ: begin
                                fr_re = 1'b1;
                                n_is_read = 1'b1;
                            end
                            ssfe_pkg::OP_FILL: begin
                                st_we   = 1'b1;
                                n_level = LW'(1);
                                n_cnt   = '0;
                                n_ovf   = 1'b0;
                            end
                            default: n_out_valid = 1'b1;
                        endcase
                    end
                end
            end
            ssfe_pkg::S_READ_WAIT: ;
            ssfe_pkg::S_POP: begin
                if (r_level != '0) begin
                    st_addr = SAW'(r_level - 1'b1);
                    st_re   = 1'b1;
                    n_level = r_level - 1'b1;
                end
            end
            ssfe_pkg::S_POP_WAIT: begin
                n_cx = r_stack_q[XW-1:0];
                n_cy = r_stack_q[AW-1:XW];
                n_xl = r_stack_q[XW-1:0];
                n_xr = r_stack_q[XW-1:0];
                fr_addr = r_stack_q;
                fr_we = 1'b1;
                n_cnt = cnt_inc;
            end
            ssfe_pkg::S_LEFT_RD: begin
                fr_addr = {r_cy, r_xl - 1'b1};
                fr_re = (r_xl != '0);
            end
            ssfe_pkg::S_LEFT_CHK: begin
                if (!is_bnd) begin
                    n_xl = r_xl - 1'b1;
                    fr_addr = {r_cy, r_xl - 1'b1};
                    fr_we = 1'b1;
                    n_cnt = cnt_inc;
                end
            end
            ssfe_pkg::S_RIGHT_RD: begin
                fr_addr = {r_cy, r_xr + 1'b1};
                fr_re = (r_xr != X_LAST);
                if (r_xr == X_LAST) begin
                    n_down = 1'b0; // first pass of SCAN_NEXT flips to below
                end
            end
            ssfe_pkg::S_RIGHT_CHK: begin
                if (!is_bnd) begin
                    n_xr = r_xr + 1'b1;
                    fr_addr = {r_cy, r_xr + 1'b1};
                    fr_we = 1'b1;
                    n_cnt = cnt_inc;
                end else begin
                    n_down = 1'b0;
                end
            end
            ssfe_pkg::S_SCAN_NEXT: begin
                // pick next row: below first, then above; skip rows off the frame
                n_x = r_xl;
                n_inrun = 1'b0;
                n_down = 1'b0;
                n_sy = r_cy - 1'b1;
                if (!r_down && r_cy != Y_LAST) begin
                    n_down = 1'b1;
                    n_sy = r_cy + 1'b1;
                end
            end
            ssfe_pkg::S_SCAN_RD: begin
                fr_addr = {r_sy, r_x};
                fr_re = 1'b1;
            end
            ssfe_pkg::S_SCAN_CHK: begin
                st_wdata = {r_sy, r_x};
                n_inrun = !is_closed;
                // push at end of run: closed pixel after a run, or open at xr
                if (r_inrun && is_closed) begin
                    st_wdata = {r_sy, r_x - 1'b1};
                end
                if ((r_inrun && is_closed) || (!is_closed && r_x == r_xr)) begin
                    if (push_ok) begin
                        st_we = 1'b1;
                        n_level = r_level + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_x = r_x + 1'b1;
            end
            ssfe_pkg::S_DONE: begin
                if (r_is_read) begin
                    n_out.read_colour = r_frame_q;
                end else begin
                    n_out.painted_count = r_cnt;
                    n_out.status = r_ovf ? ssfe_pkg::ST_OVERFLOW : ssfe_pkg::ST_OK;
                end
                n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    `SSF_ASSERT(a_ready_only_idle, i_clk, i_rst_n,
        o_in_ready |-> (r_state == ssfe_pkg::S_IDLE), "ready outside idle")
    `SSF_ASSERT(a_level_bound, i_clk, i_rst_n,
        r_level <= LEVEL_FULL, "seed stack level above depth")
    `SSF_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)),
        "result dropped while stalled")
    `SSF_ASSERT(a_level_idle, i_clk, i_rst_n,
        (r_state == ssfe_pkg::S_IDLE) |-> (r_level == '0), "stack not empty at idle")

endmodule
